### rtl/sne_pkg.sv
// ----------------------------------------------------------------------------
// sne_pkg
// Shared types and constants for the Stirling number engine.
// ----------------------------------------------------------------------------
package sne_pkg;

    localparam int VALUE_W = 64;

    localparam logic MODE_FIRST  = 1'b0;
    localparam logic MODE_SECOND = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_GAP,
        S_DONE
    } t_state;

endpackage

### rtl/sne_ram.sv
// ----------------------------------------------------------------------------
// sne_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module sne_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/stirling_number_engine_top.sv
// ----------------------------------------------------------------------------
// stirling_number_engine_top
// Stirling numbers of the first (unsigned) and second kind, modulo 2^64.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries mode, n and k. An item is
//   taken on a rising edge with i_in_valid high and o_in_stall low. One result
//   item per request leaves on o_out_valid / i_out_stall with o_value.
//   The two rows of the recurrence live in one RAM of 2*(MAX_N+1) words. A row
//   sweep reads the previous row one column a cycle through the single read
//   port, multiplies and adds, and writes the new row into the other half.
//   Each row ends in the gap state, which drains the write before the next
//   row reads it. Trivial cases (k>n, n or k zero, n beyond MAX_N) skip the
//   row sweeps and go straight to the done state.
//   One request is worked on at a time; o_in_stall is low only when idle.
//   A finished result sits in the output register while a new request is
//   accepted; a still-stalled result holds the engine in its done state.
//   Reset (synchronous, active low) returns to idle with no output pending.
//   The RAM needs no clearing: columns not written by the previous row read
//   as zero by construction.
// ----------------------------------------------------------------------------
module stirling_number_engine_top
    import sne_pkg::*;
#(
    parameter int MAX_N = 127
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [6:0]         i_n,
    input  logic [6:0]         i_k,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VALUE_W-1:0] o_value
);

    localparam int NW    = $clog2(MAX_N + 1);
    localparam int DEPTH = 2 * (MAX_N + 1);
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    logic              r_mode;
    logic [NW-1:0]     r_n, r_k, r_i, r_j;
    logic              r_sel;
    logic              r_b_valid;
    logic              r_b_rd;
    logic              r_b_last;
    logic [NW-1:0]     r_b_j;
    logic [VALUE_W-1:0] r_left;
    logic [VALUE_W-1:0] r_result;
    logic              r_out_valid;
    logic [VALUE_W-1:0] r_out_value;

    logic              accept, trivial, out_free, load_out;
    logic [VALUE_W-1:0] trivial_value;
    logic [NW-1:0]     jmax;
    logic              issue, issue_rd, issue_last;
    logic [AW-1:0]     raddr, waddr;
    logic [VALUE_W-1:0] rd_data, pv, left, product, curr;
    logic [NW-1:0]     mult;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        trivial       = 1'b1;
        trivial_value = '0;
        if (32'(i_n) > MAX_N || i_k > i_n) begin
            trivial_value = '0;
        end else if (i_n == 7'd0 && i_k == 7'd0) begin
            trivial_value = VALUE_W'(1);
        end else if (i_n == 7'd0 || i_k == 7'd0) begin
            trivial_value = '0;
        end else begin
            trivial = 1'b0;
        end
    end

    assign jmax       = (r_i < r_k) ? r_i : r_k;
    assign issue      = (r_state == S_ROW);
    assign issue_rd   = issue && (r_j < r_i);
    assign issue_last = (r_j == jmax);

    assign raddr = AW'(r_j) + (r_sel ? AW'(MAX_N + 1) : AW'(0));
    assign waddr = AW'(r_b_j) + (r_sel ? AW'(0) : AW'(MAX_N + 1));

    assign pv      = r_b_rd ? rd_data : '0;
    assign left    = (r_b_j == NW'(1)) ? ((r_i == NW'(1)) ? VALUE_W'(1) : '0) : r_left;
    assign mult    = (r_mode == MODE_SECOND) ? r_b_j : NW'(r_i - NW'(1));
    assign product = VALUE_W'(mult) * pv;
    assign curr    = product + left;

    sne_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (waddr),
        .i_wdata (curr),
        .i_re    (issue_rd),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = trivial ? S_DONE : S_ROW;
                end
            end
            S_ROW: begin
                if (issue_last) begin
                    n_state = S_GAP;
                end
            end
            S_GAP: begin
                n_state = (r_i == r_n) ? S_DONE : S_ROW;
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_b_valid <= issue;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_rd   <= issue_rd;
        r_b_last <= issue_last;
        r_b_j    <= r_j;
        if (accept) begin
            r_mode   <= i_mode;
            r_n      <= NW'(i_n);
            r_k      <= NW'(i_k);
            r_i      <= NW'(1);
            r_j      <= NW'(1);
            r_sel    <= 1'b0;
            r_result <= trivial_value;
        end
        if (issue && !issue_last) begin
            r_j <= NW'(r_j + NW'(1));
        end
        if (r_state == S_GAP && r_i != r_n) begin
            r_i   <= NW'(r_i + NW'(1));
            r_j   <= NW'(1);
            r_sel <= !r_sel;
        end
        if (r_b_valid) begin
            r_left <= pv;
            if (r_b_last && r_i == r_n) begin
                r_result <= curr;
            end
        end
        if (load_out) begin
            r_out_value <= r_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

    a_b_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_state == S_ROW || r_state == S_GAP))
        else $error("column pipeline busy outside a row sweep");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROW |-> (r_j != '0 && r_j <= r_i && r_j <= r_k))
        else $error("column index out of range");

    a_gap_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GAP |=> !r_b_valid)
        else $error("pipeline not drained at row boundary");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && issue_rd) |-> (waddr != raddr))
        else $error("read and write hit the same row entry");

    a_done_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> !issue && !r_b_valid)
        else $error("column work while result pending");

endmodule
